FILE: hw/rtl/blpw_pkg.sv
// Shared types, constants and helpers for the line pixel writer.
package blpw_pkg;

  // Frame and stride limits
  localparam int MAX_DIM    = 64;
  localparam int MAX_STRIDE = 4;

  // Field widths
  localparam int COORD_W  = 6;   // input coordinate
  localparam int PIXY_W   = 7;   // flipped row, signed
  localparam int DIM_W    = 7;   // frame width / height register
  localparam int STRIDE_W = 3;   // bytes per pixel register
  localparam int ADDR_W   = 14;  // byte address
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 8;   // signed working coordinate
  localparam int ERR_W    = 10;  // signed Bresenham error
  localparam int PITCH_W  = 9;   // frame width times stride
  localparam int SUM_W    = 10;  // r + g + b

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd2;

  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 7'd64;
  localparam logic [STRIDE_W-1:0] BPP_RST          = 3'd4;

  // Pixel layouts
  localparam logic [STRIDE_W-1:0] STRIDE_RGB  = 3'd3;
  localparam logic [STRIDE_W-1:0] STRIDE_RGBA = 3'd4;
  localparam logic [BYTE_W-1:0]   ALPHA_OPAQUE = 8'd255;

  // Divide by three: (sum * 683) >> 11 is exact for sums below 2048
  localparam int GRAY_RECIP_W = 11;
  localparam logic [GRAY_RECIP_W-1:0] GRAY_RECIP = 11'd683;
  localparam int GRAY_SHIFT = 11;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture item and clamped frame settings
    logic flip;   // flip rows, form pitch and gray
    logic swap;   // pick major axis
    logic order;  // order endpoints, set up error terms
    logic step;   // emit one pixel and advance
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;   // current pixel is the final one of the line
  } sts_t;

  // Force a frame size into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (int'(v) > MAX_DIM) res = DIM_W'(MAX_DIM);
    return res;
  endfunction

  // Force a stride into 1..MAX_STRIDE
  function automatic logic [STRIDE_W-1:0] clamp_stride(input logic [STRIDE_W-1:0] v);
    logic [STRIDE_W-1:0] res;
    res = v;
    if (v == '0) res = STRIDE_W'(1);
    else if (int'(v) > MAX_STRIDE) res = STRIDE_W'(MAX_STRIDE);
    return res;
  endfunction

endpackage

FILE: hw/rtl/blpw_ctrl.sv
// Sequencer for setup and pixel stepping, owns the output valid flag.
module blpw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output blpw_pkg::cmd_t cmd,
  input  blpw_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLIP,
    ST_SWAP,
    ST_ORDER,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_step;

  // Step only when the output register is free or being drained
  assign can_step = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  always_comb begin
    cmd       = '0;
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    cmd.flip  = (state_r == ST_FLIP);
    cmd.swap  = (state_r == ST_SWAP);
    cmd.order = (state_r == ST_ORDER);
    cmd.step  = can_step;
  end

  // Next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (can_step) out_valid_nxt = 1'b1;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_FLIP;
      ST_FLIP:  state_nxt = ST_SWAP;
      ST_SWAP:  state_nxt = ST_ORDER;
      ST_ORDER: state_nxt = ST_RUN;
      ST_RUN:   if (can_step && sts.last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/blpw_datapath.sv
// Configuration registers, line setup arithmetic, error stepper and output register.
module blpw_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [blpw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [blpw_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic [blpw_pkg::COORD_W-1:0]            in_x_start,
  input  logic [blpw_pkg::COORD_W-1:0]            in_y_start,
  input  logic [blpw_pkg::COORD_W-1:0]            in_x_end,
  input  logic [blpw_pkg::COORD_W-1:0]            in_y_end,
  input  logic [blpw_pkg::BYTE_W-1:0]             in_red,
  input  logic [blpw_pkg::BYTE_W-1:0]             in_green,
  input  logic [blpw_pkg::BYTE_W-1:0]             in_blue,
  input  blpw_pkg::cmd_t                          cmd,
  output blpw_pkg::sts_t                          sts,
  output logic [blpw_pkg::COORD_W-1:0]            out_pixel_x,
  output logic signed [blpw_pkg::PIXY_W-1:0]      out_pixel_y,
  output logic [blpw_pkg::ADDR_W-1:0]             out_byte_address,
  output logic [blpw_pkg::BYTE_W-1:0]             out_byte_zero,
  output logic [blpw_pkg::BYTE_W-1:0]             out_byte_one,
  output logic [blpw_pkg::BYTE_W-1:0]             out_byte_two,
  output logic [blpw_pkg::BYTE_W-1:0]             out_byte_three,
  output logic [blpw_pkg::STRIDE_W-1:0]           out_byte_count,
  output logic                                    out_in_bounds,
  output logic                                    out_last
);

  localparam int PW = blpw_pkg::POS_W;
  localparam int EW = blpw_pkg::ERR_W;
  localparam int BW = blpw_pkg::BYTE_W;

  // Configuration registers
  logic [blpw_pkg::DIM_W-1:0]    frame_width_r, frame_height_r;
  logic [blpw_pkg::STRIDE_W-1:0] bpp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= blpw_pkg::FRAME_WIDTH_RST;
      frame_height_r <= blpw_pkg::FRAME_HEIGHT_RST;
      bpp_r          <= blpw_pkg::BPP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        blpw_pkg::CFG_FRAME_WIDTH:     frame_width_r  <= cfg_wdata;
        blpw_pkg::CFG_FRAME_HEIGHT:    frame_height_r <= cfg_wdata;
        blpw_pkg::CFG_BYTES_PER_PIXEL: bpp_r <= cfg_wdata[blpw_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item and frame settings
  logic [blpw_pkg::COORD_W-1:0]  xs_r, ys_r, xe_r, ye_r;
  logic [BW-1:0]                 red_r, green_r, blue_r;
  logic [blpw_pkg::DIM_W-1:0]    w_r, h_r;
  logic [blpw_pkg::STRIDE_W-1:0] stride_r;
  logic [blpw_pkg::SUM_W-1:0]    sum_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r     <= in_x_start;
      ys_r     <= in_y_start;
      xe_r     <= in_x_end;
      ye_r     <= in_y_end;
      red_r    <= in_red;
      green_r  <= in_green;
      blue_r   <= in_blue;
      w_r      <= blpw_pkg::clamp_dim(frame_width_r);
      h_r      <= blpw_pkg::clamp_dim(frame_height_r);
      stride_r <= blpw_pkg::clamp_stride(bpp_r);
      sum_r    <= blpw_pkg::SUM_W'(in_red) + blpw_pkg::SUM_W'(in_green)
                + blpw_pkg::SUM_W'(in_blue);
    end
  end

  // Flip rows, form pitch and gray
  localparam int GP_W = blpw_pkg::SUM_W + blpw_pkg::GRAY_RECIP_W;
  logic signed [PW-1:0]          y0f_r, y1f_r;
  logic [blpw_pkg::PITCH_W-1:0]  pitch_r;
  logic [BW-1:0]                 gray_r;
  logic [GP_W-1:0]               gray_prod;
  logic [PW-1:0]                 h_top;

  assign h_top     = PW'(h_r) - PW'(1);
  assign gray_prod = GP_W'(sum_r) * GP_W'(blpw_pkg::GRAY_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.flip) begin
      y0f_r   <= $signed(h_top - PW'(ys_r));
      y1f_r   <= $signed(h_top - PW'(ye_r));
      pitch_r <= blpw_pkg::PITCH_W'(w_r) * blpw_pkg::PITCH_W'(stride_r);
      gray_r  <= gray_prod[blpw_pkg::GRAY_SHIFT +: BW];
    end
  end

  // Pick the major axis
  logic signed [PW-1:0] x0s, x1s, ddx, ddy;
  logic [PW-1:0]        adx, ady;
  logic                 steep_r;
  logic signed [PW-1:0] maj0_r, maj1_r, min0_r, min1_r;

  assign x0s = $signed(PW'(xs_r));
  assign x1s = $signed(PW'(xe_r));
  assign ddx = x0s - x1s;
  assign ddy = y0f_r - y1f_r;
  assign adx = ddx[PW-1] ? PW'(-ddx) : PW'(ddx);
  assign ady = ddy[PW-1] ? PW'(-ddy) : PW'(ddy);

  always_ff @(posedge clk) begin
    if (cmd.swap) begin
      steep_r <= (adx < ady);
      if (adx < ady) begin
        maj0_r <= y0f_r;
        maj1_r <= y1f_r;
        min0_r <= x0s;
        min1_r <= x1s;
      end else begin
        maj0_r <= x0s;
        maj1_r <= x1s;
        min0_r <= y0f_r;
        min1_r <= y1f_r;
      end
    end
  end

  // Order endpoints and set up the error walk
  logic                 swap_ends;
  logic signed [PW-1:0] lo_maj, hi_maj, lo_min, hi_min, dmin;
  logic [PW-1:0]        admin;

  assign swap_ends = (maj0_r > maj1_r);
  assign lo_maj    = swap_ends ? maj1_r : maj0_r;
  assign hi_maj    = swap_ends ? maj0_r : maj1_r;
  assign lo_min    = swap_ends ? min1_r : min0_r;
  assign hi_min    = swap_ends ? min0_r : min1_r;
  assign dmin      = hi_min - lo_min;
  assign admin     = dmin[PW-1] ? PW'(-dmin) : PW'(dmin);

  logic signed [PW-1:0] cur_maj_r, end_maj_r, cur_min_r;
  logic [PW-1:0]        dx_r, derr_r;
  logic                 down_r;
  logic signed [EW-1:0] err_r;

  // Error update for one step
  logic signed [EW-1:0] err_sum;
  logic                 minor_move;

  assign err_sum    = err_r + $signed(EW'(derr_r));
  assign minor_move = (err_sum > $signed(EW'(dx_r)));

  always_ff @(posedge clk) begin
    if (cmd.order) begin
      cur_maj_r <= lo_maj;
      end_maj_r <= hi_maj;
      cur_min_r <= lo_min;
      dx_r      <= PW'(hi_maj - lo_maj);
      derr_r    <= PW'({admin, 1'b0});
      down_r    <= !(hi_min > lo_min);
      err_r     <= '0;
    end else if (cmd.step) begin
      cur_maj_r <= cur_maj_r + PW'(1);
      if (minor_move) begin
        cur_min_r <= down_r ? cur_min_r - PW'(1) : cur_min_r + PW'(1);
        err_r     <= err_sum - $signed(EW'({dx_r, 1'b0}));
      end else begin
        err_r     <= err_sum;
      end
    end
  end

  assign sts.last = (cur_maj_r == end_maj_r);

  // Pixel position, clipping and address
  localparam int AP_W = blpw_pkg::ADDR_W + 1;
  logic signed [PW-1:0] px, py;
  logic                 inb;
  logic [AP_W-1:0]      addr_full;

  assign px  = steep_r ? cur_min_r : cur_maj_r;
  assign py  = steep_r ? cur_maj_r : cur_min_r;
  assign inb = !px[PW-1] && (px[blpw_pkg::DIM_W-1:0] < w_r)
            && !py[PW-1] && (py[blpw_pkg::DIM_W-1:0] < h_r);
  assign addr_full = AP_W'(px[blpw_pkg::COORD_W-1:0]) * AP_W'(stride_r)
                   + AP_W'(py[blpw_pkg::COORD_W-1:0]) * AP_W'(pitch_r);

  // Byte layout by stride
  logic [BW-1:0] b0, b1, b2, b3;

  always_comb begin
    if (stride_r == blpw_pkg::STRIDE_RGB) begin
      b0 = red_r;  b1 = green_r;  b2 = blue_r;  b3 = gray_r;
    end else if (stride_r == blpw_pkg::STRIDE_RGBA) begin
      b0 = red_r;  b1 = green_r;  b2 = blue_r;  b3 = blpw_pkg::ALPHA_OPAQUE;
    end else begin
      b0 = gray_r; b1 = gray_r;   b2 = gray_r;  b3 = gray_r;
    end
  end

  // Output register, loaded on each step
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_pixel_x      <= px[blpw_pkg::COORD_W-1:0];
      out_pixel_y      <= py[blpw_pkg::PIXY_W-1:0];
      out_byte_address <= inb ? addr_full[blpw_pkg::ADDR_W-1:0] : '0;
      out_byte_zero    <= b0;
      out_byte_one     <= b1;
      out_byte_two     <= b2;
      out_byte_three   <= b3;
      out_byte_count   <= stride_r;
      out_in_bounds    <= inb;
      out_last         <= sts.last;
    end
  end

endmodule

FILE: hw/rtl/bresenham_line_pixel_writer_top.sv
// Top level of the Bresenham line pixel writer: controller plus datapath.
//
//  channel | direction | handshake          | contents
//  in_     | input     | in_valid/in_ready  | endpoints x/y start and end, red, green, blue
//  out_    | output    | out_valid/out_ready| pixel x/y, byte address, four bytes, count,
//          |           |                    | in-bounds flag, last marker
//  cfg_    | input     | cfg_wr_en          | frame width, frame height, bytes per pixel
//
// Setup runs capture, row flip, axis pick and endpoint order in that order,
// and then the stepper walks the line pixel by pixel.
// The pixel stepper produces one pixel per cycle; a stalled out_ready holds it.
// in_ready is high while no line is being walked; the last pixel may still
// wait in the output register when the next item is taken.
// Reset is synchronous, active low, and restores 64 x 64 frame, 4 bytes/pixel.
module bresenham_line_pixel_writer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [blpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blpw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [blpw_pkg::COORD_W-1:0]        in_x_start,
  input  logic [blpw_pkg::COORD_W-1:0]        in_y_start,
  input  logic [blpw_pkg::COORD_W-1:0]        in_x_end,
  input  logic [blpw_pkg::COORD_W-1:0]        in_y_end,
  input  logic [blpw_pkg::BYTE_W-1:0]         in_red,
  input  logic [blpw_pkg::BYTE_W-1:0]         in_green,
  input  logic [blpw_pkg::BYTE_W-1:0]         in_blue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [blpw_pkg::COORD_W-1:0]        out_pixel_x,
  output logic signed [blpw_pkg::PIXY_W-1:0]  out_pixel_y,
  output logic [blpw_pkg::ADDR_W-1:0]         out_byte_address,
  output logic [blpw_pkg::BYTE_W-1:0]         out_byte_zero,
  output logic [blpw_pkg::BYTE_W-1:0]         out_byte_one,
  output logic [blpw_pkg::BYTE_W-1:0]         out_byte_two,
  output logic [blpw_pkg::BYTE_W-1:0]         out_byte_three,
  output logic [blpw_pkg::STRIDE_W-1:0]       out_byte_count,
  output logic                                out_in_bounds,
  output logic                                out_last
);

  blpw_pkg::cmd_t cmd;
  blpw_pkg::sts_t sts;

  blpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  blpw_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_x_start       (in_x_start),
    .in_y_start       (in_y_start),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .cmd              (cmd),
    .sts              (sts),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_byte_address (out_byte_address),
    .out_byte_zero    (out_byte_zero),
    .out_byte_one     (out_byte_one),
    .out_byte_two     (out_byte_two),
    .out_byte_three   (out_byte_three),
    .out_byte_count   (out_byte_count),
    .out_in_bounds    (out_in_bounds),
    .out_last         (out_last)
  );

endmodule

FILE: hw/rtl/blpw_checker.sv
// Port-level checks for the line pixel writer, bound to the top level.
module blpw_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [blpw_pkg::COORD_W-1:0]        out_pixel_x,
  input  logic signed [blpw_pkg::PIXY_W-1:0]  out_pixel_y,
  input  logic [blpw_pkg::ADDR_W-1:0]         out_byte_address,
  input  logic [blpw_pkg::BYTE_W-1:0]         out_byte_zero,
  input  logic [blpw_pkg::BYTE_W-1:0]         out_byte_one,
  input  logic [blpw_pkg::BYTE_W-1:0]         out_byte_two,
  input  logic [blpw_pkg::BYTE_W-1:0]         out_byte_three,
  input  logic [blpw_pkg::STRIDE_W-1:0]       out_byte_count,
  input  logic                                out_in_bounds,
  input  logic                                out_last
);

  // A taken item blocks the input while setup runs
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an item was taken");

  // Clipped pixels carry a zero address
  a_clip_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_bounds) |-> (out_byte_address == '0))
    else $error("out-of-bounds pixel with nonzero address");

  // Stride stays inside its clamped range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count != '0 && out_byte_count <= blpw_pkg::STRIDE_RGBA))
    else $error("byte count outside 1..4");

  // Four-byte pixels are opaque
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_count == blpw_pkg::STRIDE_RGBA)
      |-> (out_byte_three == blpw_pkg::ALPHA_OPAQUE))
    else $error("RGBA pixel without opaque alpha");

  // Stalled result holds every field
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel_x)
      && $stable(out_pixel_y) && $stable(out_byte_address)
      && $stable(out_byte_zero) && $stable(out_byte_one)
      && $stable(out_byte_two) && $stable(out_byte_three)
      && $stable(out_byte_count) && $stable(out_in_bounds) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind bresenham_line_pixel_writer_top blpw_checker u_blpw_checker (.*);
